FILE: rtl/bht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bht_pkg: shared types and constants for the bucketed hash table
// Request modes, result status codes, field widths and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package bht_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int MODE_W = 3;
	localparam int ST_W = 2;
	localparam int SLOT_OUT_W = 2;

	localparam int DEF_BUCKETS = 64;
	localparam int DEF_SLOTS = 4;

	localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_MULTI = 3'd1;
	localparam logic [MODE_W-1:0] MODE_GET = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REMOVE_PAIR = 3'd4;

	localparam logic [ST_W-1:0] ST_DONE = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;      // capture request and start the home bucket reduction
		logic set_home;  // set probe to home bucket
		logic rd_row;    // read fill count of current bucket
		logic scan;      // step slot scan of current bucket
		logic nxt_bkt;   // advance probe to the following bucket
		logic wr_ins;    // write key/value at the insert slot, bump fill
		logic wr_upd;    // write value at the hit slot
		logic shift;     // move one entry down within the bucket
		logic dec_fill;  // lower fill count of the current bucket
		logic set_res;   // latch result fields
		logic [ST_W-1:0] res_st;
	} bht_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic hit;       // current slot matches
		logic scan_end;  // current slot is the last one below the fill count
		logic empty;     // current bucket holds no entry
		logic room;      // current bucket has a free slot
		logic last_bkt;  // current bucket is the last in probe order
		logic shift_end; // no more entries to move down
		logic clr_busy;  // fill counts still being cleared after reset
		logic [MODE_W-1:0] mode;
	} bht_sts_t;

endpackage

`default_nettype wire

FILE: rtl/bht_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bht_datapath: key/value stores, fill counts and probe registers
// Holds the request, walks one slot per cycle over the current bucket and
// performs inserts, updates and the shift-down after a removal.
// ----------------------------------------------------------------------------
module bht_datapath import bht_pkg::*; #(
	parameter int BUCKETS = DEF_BUCKETS,
	parameter int SLOTS = DEF_SLOTS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [MODE_W-1:0] in_mode,
	input  wire logic [KEY_W-1:0] in_key,
	input  wire logic [VAL_W-1:0] in_value,
	input  wire bht_cmd_t cmd,
	output bht_sts_t sts,
	output logic [ST_W-1:0] res_status,
	output logic [SLOT_OUT_W-1:0] res_slot,
	output logic [VAL_W-1:0] res_value
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FW = $clog2(SLOTS + 1);
	localparam int DEPTH = BUCKETS * SLOTS;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = 2 * KEY_W + 1;
	localparam int QW = KEY_W + 1 - BW;
	// reciprocal of BUCKETS scaled by 2^(KEY_W+BW), rounded up: exact quotient
	// for every key
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << (KEY_W + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam logic [KEY_W:0] RECIP = RECIP_FULL[KEY_W:0];

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [VAL_W-1:0] val_mem [DEPTH];
	logic [FW-1:0] fill_mem [BUCKETS];

	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [QW-1:0] quo_q;
	logic [BW-1:0] bkt_q;
	logic [BW-1:0] home_q;
	logic [SW-1:0] slot_q;
	logic [FW-1:0] fill_q;
	logic [KEY_W-1:0] rkey_q;
	logic [VAL_W-1:0] rval_q;
	logic [ST_W-1:0] st_q;
	logic [SLOT_OUT_W-1:0] rslot_q;
	logic [VAL_W-1:0] rvo_q;
	logic [BW-1:0] clr_q;
	logic clr_busy_q;

	logic [PW-1:0] prod;
	logic [BW-1:0] home_calc;
	logic [BW-1:0] bkt_nxt;
	logic [AW-1:0] addr;
	logic [AW-1:0] addr_nxt;
	logic [FW-1:0] slot_ext;
	logic [FW-1:0] slot_inc;
	logic hit;

	// home bucket: quotient by reciprocal multiply at accept, then the
	// remainder from its low bits in the next cycle
	assign prod = PW'(in_key) * PW'(RECIP);
	assign home_calc = key_q[BW-1:0] - BW'(quo_q[BW-1:0] * BW'(BUCKETS));

	assign bkt_nxt = (bkt_q == BW'(BUCKETS - 1)) ? '0 : bkt_q + 1'b1;
	assign addr = AW'(bkt_q) * AW'(SLOTS) + AW'(slot_q);
	assign addr_nxt = addr + 1'b1;
	assign slot_ext = FW'(slot_q);
	assign slot_inc = slot_ext + 1'b1;
	assign hit = (rkey_q == key_q) && ((mode_q != MODE_REMOVE_PAIR) || (rval_q == val_q));

	always_comb begin
		sts.hit = hit;
		sts.scan_end = (slot_inc >= fill_q);
		sts.empty = (fill_q == '0);
		sts.room = (fill_q < FW'(SLOTS));
		sts.last_bkt = (bkt_nxt == home_q);
		sts.shift_end = (slot_inc >= fill_q);
		sts.clr_busy = clr_busy_q;
		sts.mode = mode_q;
	end

	// probe position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_q <= '0;
			slot_q <= '0;
		end else if (cmd.set_home) begin
			bkt_q <= home_calc;
			slot_q <= '0;
		end else if (cmd.nxt_bkt) begin
			bkt_q <= bkt_nxt;
			slot_q <= '0;
		end else if (cmd.scan || cmd.shift) begin
			slot_q <= slot_q + 1'b1;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			key_q <= in_key;
			val_q <= in_value;
			quo_q <= prod[PW-1:KEY_W+BW];
		end
		if (cmd.set_home) begin
			home_q <= home_calc;
		end
	end

	// clearing pass over the fill counts after reset, one bucket a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == BW'(BUCKETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// fill counts
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			fill_mem[clr_q] <= '0;
		end else if (cmd.wr_ins) begin
			fill_mem[bkt_q] <= fill_q + 1'b1;
		end else if (cmd.dec_fill) begin
			fill_mem[bkt_q] <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.rd_row) begin
			fill_q <= fill_mem[bkt_q];
		end
	end

	// entry memory: read current slot (or next slot while shifting or latching a result)
	always_ff @(posedge clk) begin
		if (cmd.wr_ins) begin
			key_mem[AW'(bkt_q) * AW'(SLOTS) + AW'(fill_q)] <= key_q;
			val_mem[AW'(bkt_q) * AW'(SLOTS) + AW'(fill_q)] <= val_q;
		end else if (cmd.wr_upd) begin
			val_mem[addr] <= val_q;
		end else if (cmd.shift) begin
			key_mem[addr] <= rkey_q;
			val_mem[addr] <= rval_q;
		end
		if (cmd.shift || cmd.set_res) begin
			rkey_q <= key_mem[addr_nxt + (cmd.shift ? AW'(1) : AW'(0))];
			rval_q <= val_mem[addr_nxt + (cmd.shift ? AW'(1) : AW'(0))];
		end else begin
			rkey_q <= key_mem[cmd.scan ? addr_nxt : addr];
			rval_q <= val_mem[cmd.scan ? addr_nxt : addr];
		end
	end

	// result latch
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			st_q <= cmd.res_st;
			rslot_q <= '0;
			rvo_q <= '0;
			if (cmd.res_st == ST_DONE) begin
				if (mode_q == MODE_ADD || mode_q == MODE_ADD_MULTI) begin
					rslot_q <= SLOT_OUT_W'(cmd.wr_ins ? fill_q : slot_ext);
				end else begin
					rvo_q <= rval_q;
				end
			end
		end
	end

	assign res_status = st_q;
	assign res_slot = rslot_q;
	assign res_value = rvo_q;

endmodule

`default_nettype wire

FILE: rtl/bht_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bht_ctrl: request sequencer for the bucketed hash table
// Steps through probe buckets and slots, issues datapath commands and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module bht_ctrl import bht_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire bht_sts_t sts,
	output bht_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ROW = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;
	localparam logic [2:0] S_HOME = 3'd6;

	logic [2:0] state_q, state_d;
	logic vld_q;
	logic is_ins, is_srch;

	assign is_ins = (sts.mode == MODE_ADD) || (sts.mode == MODE_ADD_MULTI);
	assign is_srch = (sts.mode == MODE_GET) || (sts.mode == MODE_REMOVE)
		|| (sts.mode == MODE_REMOVE_PAIR);
	assign in_ready = (state_q == S_IDLE) && !sts.clr_busy && !(vld_q && !out_ready);
	assign out_valid = vld_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d = S_HOME;
				end
			end
			S_HOME: begin
				cmd.set_home = 1'b1;
				state_d = S_ROW;
			end
			S_ROW: begin
				cmd.rd_row = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (!is_ins && !is_srch) begin
					cmd.set_res = 1'b1;
					cmd.res_st = ST_MISS;
					state_d = S_OUT;
				end else if (sts.empty || (sts.mode == MODE_ADD_MULTI)) begin
					if (is_ins && sts.room) begin
						cmd.wr_ins = 1'b1;
						cmd.set_res = 1'b1;
						cmd.res_st = ST_DONE;
						state_d = S_OUT;
					end else if (sts.last_bkt) begin
						cmd.set_res = 1'b1;
						cmd.res_st = is_ins ? ST_FULL : ST_MISS;
						state_d = S_OUT;
					end else begin
						cmd.nxt_bkt = 1'b1;
						state_d = S_ROW;
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					if (sts.mode == MODE_ADD) begin
						cmd.wr_upd = 1'b1;
						cmd.set_res = 1'b1;
						cmd.res_st = ST_DONE;
						state_d = S_OUT;
					end else if (sts.mode == MODE_GET) begin
						cmd.set_res = 1'b1;
						cmd.res_st = ST_DONE;
						state_d = S_OUT;
					end else begin
						cmd.set_res = 1'b1;
						cmd.res_st = ST_DONE;
						state_d = S_SHIFT;
					end
				end else if (!sts.scan_end) begin
					cmd.scan = 1'b1;
				end else if (is_ins && sts.room) begin
					cmd.wr_ins = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res_st = ST_DONE;
					state_d = S_OUT;
				end else if (sts.last_bkt) begin
					cmd.set_res = 1'b1;
					cmd.res_st = is_ins ? ST_FULL : ST_MISS;
					state_d = S_OUT;
				end else begin
					cmd.nxt_bkt = 1'b1;
					state_d = S_ROW;
				end
			end
			S_SHIFT: begin
				if (sts.shift_end) begin
					cmd.dec_fill = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT) begin
				vld_q <= 1'b1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bucketed_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_hash_table: key/value table with bucket-wise linear probing
//
// channel  | dir | fields (low bit first)
// s_axis   | in  | tdata: mode[2:0] key[33:3] value[65:34], 72 bits
// m_axis   | out | tdata: status[1:0] slot[3:2] value_out[35:4], 40 bits
//
// One request at a time, passing through accept, home bucket, fill count
// read, decide and result. Each further bucket probed adds another fill count
// read and decide, each slot compared in an occupied bucket adds a scan step,
// and a removal adds a shift per entry moved down and a step to lower the fill count.
// After reset the fill counts are cleared one bucket a cycle, with the input
// held off until every bucket is done.
// The result waits in an output register; the next request is taken
// once that result has left or leaves in the same cycle.
// ----------------------------------------------------------------------------
module bucketed_hash_table import bht_pkg::*; #(
	parameter int BUCKETS = DEF_BUCKETS,
	parameter int SLOTS = DEF_SLOTS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [71:0] s_axis_tdata, // mode, key, value
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [39:0] m_axis_tdata // status, slot, value_out
);

	bht_cmd_t cmd;
	bht_sts_t sts;
	logic [ST_W-1:0] res_status;
	logic [SLOT_OUT_W-1:0] res_slot;
	logic [VAL_W-1:0] res_value;

	bht_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts(sts),
		.cmd(cmd)
	);

	bht_datapath #(
		.BUCKETS(BUCKETS),
		.SLOTS(SLOTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_mode(s_axis_tdata[2:0]),
		.in_key(s_axis_tdata[33:3]),
		.in_value(s_axis_tdata[65:34]),
		.cmd(cmd),
		.sts(sts),
		.res_status(res_status),
		.res_slot(res_slot),
		.res_value(res_value)
	);

	assign m_axis_tdata = {4'd0, res_value, res_slot, res_status};

endmodule

`default_nettype wire
